// ===== rtl/core/lpfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpfp_pkg;

	localparam int unsigned MagicLen = 7;

	// Parse phases, one-hot.
	typedef enum logic [8:0] {
		PH_MAGIC   = 9'b000000001,
		PH_TLEN_HI = 9'b000000010,
		PH_TLEN_LO = 9'b000000100,
		PH_TYPE    = 9'b000001000,
		PH_NLEN_HI = 9'b000010000,
		PH_NLEN_LO = 9'b000100000,
		PH_NAME    = 9'b001000000,
		PH_CONTENT = 9'b010000000,
		PH_DISCARD = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_TYPE    = 2'd1,
		KIND_NAME    = 2'd2,
		KIND_CONTENT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_PENDING   = 2'd0,
		ST_OK        = 2'd1,
		ST_BADMAGIC  = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	// One tagged result word.
	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      byte_kind;
		logic       blob_end;
		status_t    frame_status;
	} result_t;

	// Expected magic byte at a given position of the prefix.
	function automatic logic [7:0] magic_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = 8'h00;
			3'd1: b = 8'h46;
			3'd2: b = 8'h42;
			3'd3: b = 8'h41;
			3'd4: b = 8'h54;
			3'd5: b = 8'h31;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpfp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfp_parse (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  wire  [7:0]             data_byte,
	input  wire                    last_byte,
	output lpfp_pkg::result_t      result
);
	import lpfp_pkg::*;

	phase_t      phase_q;
	logic [2:0]  magic_pos_q;
	logic [15:0] remaining_q;
	logic [7:0]  len_high_q;
	logic        magic_failed_q;

	phase_t      phase_d;
	logic [2:0]  magic_pos_d;
	logic [15:0] remaining_d;
	logic [7:0]  len_high_d;
	logic        magic_failed_d;
	logic [15:0] len_full;
	logic [15:0] rem_dec;
	kind_t       kind;
	status_t     status;

	assign len_full = {len_high_q, data_byte};
	assign rem_dec  = remaining_q - 16'd1;

	// Next state and tag for the word being processed.
	always_comb begin
		phase_d        = phase_q;
		magic_pos_d    = magic_pos_q;
		remaining_d    = remaining_q;
		len_high_d     = len_high_q;
		magic_failed_d = magic_failed_q;
		kind           = KIND_HEADER;
		case (phase_q)
			PH_MAGIC: begin
				if (data_byte != magic_byte(magic_pos_q)) begin
					magic_failed_d = 1'b1;
				end
				if (magic_pos_q == 3'(MagicLen - 1)) begin
					magic_pos_d = 3'd0;
					phase_d     = magic_failed_d ? PH_DISCARD : PH_TLEN_HI;
				end else begin
					magic_pos_d = magic_pos_q + 3'd1;
				end
			end
			PH_TLEN_HI: begin
				len_high_d = data_byte;
				phase_d    = PH_TLEN_LO;
			end
			PH_NLEN_HI: begin
				len_high_d = data_byte;
				phase_d    = PH_NLEN_LO;
			end
			PH_TLEN_LO: begin
				remaining_d = len_full;
				phase_d     = (len_full == 16'd0) ? PH_NLEN_HI : PH_TYPE;
			end
			PH_NLEN_LO: begin
				remaining_d = len_full;
				phase_d     = (len_full == 16'd0) ? PH_CONTENT : PH_NAME;
			end
			PH_TYPE: begin
				kind        = KIND_TYPE;
				remaining_d = rem_dec;
				if (rem_dec == 16'd0) begin
					phase_d = PH_NLEN_HI;
				end
			end
			PH_NAME: begin
				kind        = KIND_NAME;
				remaining_d = rem_dec;
				if (rem_dec == 16'd0) begin
					phase_d = PH_CONTENT;
				end
			end
			PH_CONTENT: begin
				kind = KIND_CONTENT;
			end
			default: begin
				phase_d = PH_DISCARD;
			end
		endcase
	end

	// Status is reported only on the closing word of a blob.
	always_comb begin
		status = ST_PENDING;
		if (last_byte) begin
			if (magic_failed_d || phase_d == PH_MAGIC || phase_d == PH_DISCARD) begin
				status = ST_BADMAGIC;
			end else if (phase_d == PH_CONTENT) begin
				status = ST_OK;
			end else begin
				status = ST_TRUNCATED;
			end
		end
	end

	assign result.out_byte     = data_byte;
	assign result.byte_kind    = kind;
	assign result.blob_end     = last_byte;
	assign result.frame_status = status;

	// Parser state; the closing word returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_MAGIC;
			magic_pos_q    <= 3'd0;
			remaining_q    <= 16'd0;
			len_high_q     <= 8'd0;
			magic_failed_q <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				phase_q        <= PH_MAGIC;
				magic_pos_q    <= 3'd0;
				remaining_q    <= 16'd0;
				len_high_q     <= 8'd0;
				magic_failed_q <= 1'b0;
			end else begin
				phase_q        <= phase_d;
				magic_pos_q    <= magic_pos_d;
				remaining_q    <= remaining_d;
				len_high_q     <= len_high_d;
				magic_failed_q <= magic_failed_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_frame_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Word fields
// input     in_valid, in_ready    data_byte, last_byte
// output    out_valid, out_ready  out_byte, byte_kind, blob_end, frame_status
//
// One word is accepted per cycle and one tagged word is produced per cycle while
// the output is not stalled. An accepted word is held in the input register and
// is parsed into the output register when it can load, and out_valid then rises.
// Reset puts the parser back in the magic phase and empties both registers.
// A stall at the output holds the output register, and a full input register
// waits behind it; input ready drops only while both are full and the output
// is stalled, so throughput stays at one word per cycle while drained.

module length_prefixed_frame_parser_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] data_byte,
	input  wire        last_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] byte_kind,
	output logic       blob_end,
	output logic [1:0] frame_status
);
	import lpfp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       valid_s2;
	result_t    result_s2;
	result_t    result;
	logic       adv_s2;
	logic       adv_s1;

	// Stage 2 can load when empty or when its word is being taken.
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	lpfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign out_byte     = result_s2.out_byte;
	assign byte_kind    = result_s2.byte_kind;
	assign blob_end     = result_s2.blob_end;
	assign frame_status = result_s2.frame_status;

endmodule

`default_nettype wire

// ===== rtl/core/lpfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfp_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte,
	input wire [1:0] byte_kind,
	input wire       blob_end,
	input wire [1:0] frame_status
);
	import lpfp_pkg::*;

	// A status appears only on the closing word.
	a_pending_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !blob_end |-> frame_status == ST_PENDING)
		else $error("status reported before blob end");

	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blob_end |-> frame_status != ST_PENDING)
		else $error("no status on closing word");

	// Content can only be reached once the name is complete.
	a_content_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blob_end && byte_kind == KIND_CONTENT |-> frame_status == ST_OK)
		else $error("content word closed blob with status other than ok");

	// A blob that ends inside the type text never has its name.
	a_type_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blob_end && byte_kind == KIND_TYPE |-> frame_status == ST_TRUNCATED)
		else $error("blob ending in type text not flagged truncated");

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_kind)
			&& $stable(blob_end) && $stable(frame_status))
		else $error("output word changed while stalled");

endmodule

bind length_prefixed_frame_parser_core lpfp_checker u_lpfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.byte_kind    (byte_kind),
	.blob_end     (blob_end),
	.frame_status (frame_status)
);

`default_nettype wire

// ===== tb/length_prefixed_frame_parser_core_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_frame_parser_core_tb;
	import lpfp_pkg::*;

	// Fixed prefix of every frame, first byte in the top bits.
	localparam logic [55:0] FRAME_MAGIC = 56'h00_46_42_41_54_31_00;
	localparam int          MAGIC_BYTES = 7;
	localparam int          RANDOM_WORDS = 1000;
	localparam int          TOTAL_WORDS = 1150;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic       blob_end;
	logic [1:0] frame_status;

	// Tracked parser state, mirrored on every accepted input word.
	phase_t      trk_phase;
	logic [2:0]  trk_magic_pos;
	logic [15:0] trk_remaining;
	logic [7:0]  trk_len_high;
	logic        trk_magic_bad;

	result_t     pending_words[$];
	logic [7:0]  blob_q[$];
	int          mismatch_count;
	int          words_sent;
	bit          idle_en;

	length_prefixed_frame_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_kind    (byte_kind),
		.blob_end     (blob_end),
		.frame_status (frame_status)
	);

	always #4 clk = ~clk;

	function automatic void reset_tracker();
		trk_phase = PH_MAGIC;
		trk_magic_pos = 3'd0;
		trk_remaining = 16'd0;
		trk_len_high = 8'd0;
		trk_magic_bad = 1'b0;
	endfunction

	// Works out the tagged word for one input byte and advances the tracked state.
	function automatic result_t predict_tag(input logic [7:0] data, input logic is_last);
		result_t     r;
		phase_t      nxt;
		logic [15:0] len;
		r.out_byte = data;
		r.byte_kind = KIND_HEADER;
		r.blob_end = is_last;
		r.frame_status = ST_PENDING;
		nxt = trk_phase;
		case (trk_phase)
			PH_MAGIC: begin
				if (data != FRAME_MAGIC[55 - 8 * trk_magic_pos -: 8])
					trk_magic_bad = 1'b1;
				trk_magic_pos = trk_magic_pos + 3'd1;
				if (trk_magic_pos >= MAGIC_BYTES) begin
					trk_magic_pos = 3'd0;
					nxt = trk_magic_bad ? PH_DISCARD : PH_TLEN_HI;
				end
			end
			PH_TLEN_HI, PH_NLEN_HI: begin
				trk_len_high = data;
				nxt = (trk_phase == PH_TLEN_HI) ? PH_TLEN_LO : PH_NLEN_LO;
			end
			PH_TLEN_LO, PH_NLEN_LO: begin
				len = {trk_len_high, data};
				trk_remaining = len;
				if (trk_phase == PH_TLEN_LO)
					nxt = (len == 16'd0) ? PH_NLEN_HI : PH_TYPE;
				else
					nxt = (len == 16'd0) ? PH_CONTENT : PH_NAME;
			end
			PH_TYPE, PH_NAME: begin
				r.byte_kind = (trk_phase == PH_TYPE) ? KIND_TYPE : KIND_NAME;
				trk_remaining = trk_remaining - 16'd1;
				if (trk_remaining == 16'd0)
					nxt = (trk_phase == PH_TYPE) ? PH_NLEN_HI : PH_CONTENT;
			end
			PH_CONTENT: begin
				r.byte_kind = KIND_CONTENT;
			end
			default: begin
				nxt = PH_DISCARD;
			end
		endcase
		trk_phase = nxt;

		// The closing word carries the verdict and the parser starts over.
		if (is_last) begin
			if (trk_magic_bad || nxt == PH_MAGIC || nxt == PH_DISCARD)
				r.frame_status = ST_BADMAGIC;
			else if (nxt == PH_CONTENT)
				r.frame_status = ST_OK;
			else
				r.frame_status = ST_TRUNCATED;
			reset_tracker();
		end
		return r;
	endfunction

	// Sends one word, with an optional idle burst first, and records its expectation.
	task automatic send_word(input logic [7:0] data, input logic is_last);
		result_t exp_word;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= data;
		last_byte <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		exp_word = predict_tag(data, is_last);
		pending_words = {pending_words, exp_word};
		words_sent++;
	endtask

	task automatic send_blob();
		for (int i = 0; i < blob_q.size(); i++)
			send_word(blob_q[i], i == blob_q.size() - 1);
	endtask

	// Holds the input idle until every expected word has come out.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// Appends one byte to the blob under construction.
	function automatic void add_byte(input logic [7:0] b);
		blob_q = {blob_q, b};
	endfunction

	task automatic push_magic();
		for (int i = 0; i < MAGIC_BYTES; i++)
			add_byte(FRAME_MAGIC[55 - 8 * i -: 8]);
	endtask

	// Builds a complete frame with random text and content bytes.
	task automatic build_frame(input int type_len, input int name_len, input int body_len);
		blob_q.delete();
		push_magic();
		add_byte(type_len[15:8]);
		add_byte(type_len[7:0]);
		repeat (type_len) add_byte(8'($urandom_range(0, 255)));
		add_byte(name_len[15:8]);
		add_byte(name_len[7:0]);
		repeat (name_len) add_byte(8'($urandom_range(0, 255)));
		repeat (body_len) add_byte(8'($urandom_range(0, 255)));
	endtask

	// Mostly short text fields, now and then one past 255 bytes.
	function automatic int pick_len();
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(256, 300);
		return $urandom_range(0, 4);
	endfunction

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each accepted output word against the oldest expectation.
	always @(posedge clk) begin
		result_t w;
		if (out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: extra word, expected none, actual %0d %0d %0d %0d",
					$time, out_byte, byte_kind, blob_end, frame_status);
				mismatch_count++;
			end else begin
				w = pending_words.pop_front();
				check_field("out_byte", w.out_byte, out_byte);
				check_field("byte_kind", w.byte_kind, byte_kind);
				check_field("blob_end", w.blob_end, blob_end);
				check_field("frame_status", w.frame_status, frame_status);
			end
		end
	end

	// Output back-pressure in random bursts while idling is enabled.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// A well-formed frame with a type byte, an empty name and one content byte,
	// then a one-byte blob and a frame whose last magic byte is wrong.
	task automatic test_directed();
		blob_q.delete();
		push_magic();
		add_byte(8'h00);
		add_byte(8'h01);
		add_byte(8'h80);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'hFF);
		send_blob();

		blob_q.delete();
		add_byte(8'hFF);
		send_blob();

		blob_q.delete();
		push_magic();
		blob_q[MAGIC_BYTES - 1] = 8'hFF;
		add_byte(8'h00);
		send_blob();
		wait_drained();
	endtask

	// Random blobs: mostly complete frames, plus cut, corrupted and noise blobs.
	task automatic test_random_frames(input int word_goal);
		int sel;
		int cut;
		int pos;
		while (words_sent < word_goal) begin
			sel = $urandom_range(0, 99);
			if (sel < 65) begin
				build_frame(pick_len(), pick_len(), $urandom_range(0, 6));
			end else if (sel < 75) begin
				build_frame(pick_len(), pick_len(), $urandom_range(0, 3));
				cut = $urandom_range(1, blob_q.size());
				while (blob_q.size() > cut)
					void'(blob_q.pop_back());
			end else if (sel < 82) begin
				// Header with arbitrary lengths that ends early.
				blob_q.delete();
				push_magic();
				repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
			end else if (sel < 92) begin
				build_frame(pick_len(), pick_len(), $urandom_range(0, 3));
				pos = $urandom_range(0, MAGIC_BYTES - 1);
				blob_q[pos] = blob_q[pos] ^ 8'($urandom_range(1, 255));
				cut = $urandom_range(1, blob_q.size());
				while (blob_q.size() > cut)
					void'(blob_q.pop_back());
			end else begin
				blob_q.delete();
				repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
			end
			send_blob();
			if (idle_en && $urandom_range(0, 19) == 0)
				wait_drained();
		end
	endtask

	// Back-to-back traffic with both sides always ready.
	task automatic test_streaming();
		idle_en = 1'b0;
		test_random_frames(TOTAL_WORDS);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		out_ready = 1'b0;
		mismatch_count = 0;
		words_sent = 0;
		idle_en = 1'b1;
		reset_tracker();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_frames(RANDOM_WORDS);
		test_streaming();

		wait_drained();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
